>>> rtl/tabulated_radial_sampler_assert.svh
// ----------------------------------------------------------------------------
// Tabulated radial sampler assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TABULATED_RADIAL_SAMPLER_ASSERT_SVH
`define TABULATED_RADIAL_SAMPLER_ASSERT_SVH
`ifndef SYNTH
`define TRS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("tabulated_radial_sampler assertion failed");
`define TRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("tabulated_radial_sampler assertion failed");
`else
`define TRS_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define TRS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/trs_pkg.sv
// ----------------------------------------------------------------------------
// Tabulated radial sampler package
// Sizes, command and status codes shared by the sampler.
// ----------------------------------------------------------------------------
package trs_pkg;

  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int unsigned R_W   = 24;
  localparam int unsigned DEN_W = 24;
  localparam int unsigned U_W   = 24;
  localparam int unsigned DO_W  = 32;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned CW_W  = 64;

  // shared shift-add / shift-subtract unit
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned DIV_N_W = 49;
  localparam int unsigned ACNT_W  = $clog2(DIV_N_W);
  localparam int unsigned PROD_W  = CW_W + MUL_B_W;

  localparam logic [23:0] FOURPI_Q20 = 24'd13176795;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_SAMPLE  = 2'd2,
    CMD_DENSITY = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    STS_OK          = 3'd0,
    STS_TOO_FEW     = 3'd1,
    STS_ZERO_WEIGHT = 3'd2,
    STS_FULL        = 3'd3,
    STS_NOT_BUILT   = 3'd4
  } status_e;

endpackage

>>> rtl/tabulated_radial_sampler.sv
// ----------------------------------------------------------------------------
// Tabulated radial sampler
// Sorted (radius, density) table, cumulative shell weights, inverse transform
// sampling and normalized density lookup on one shared shift-add/sub unit.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// command  | in        | start, busy        | cmd_i radius_i point_density_i uniform_i
// result   | out       | done_o (one cycle) | radius_out_o density_out_o status_o
//
// Status-only replies leave busy low; a load shifts larger entries up one place.
// Finish: three multiplies per point on the shared unit.
// Sample: two multiplies, then a binary search, plus a midpoint average;
// density: a binary search and interpolation (skipped below the first radius).
// busy is high from accept until the done_o beat; the receiver cannot stall.
// Reset clears the point count, ready flag and sequencer; tables need no clear.
// ----------------------------------------------------------------------------
`include "tabulated_radial_sampler_assert.svh"

module tabulated_radial_sampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd_i,
  input  logic [trs_pkg::R_W-1:0]     radius_i,
  input  logic [trs_pkg::DEN_W-1:0]   point_density_i,
  input  logic [trs_pkg::U_W-1:0]     uniform_i,
  output logic                        done_o,
  output logic [trs_pkg::R_W-1:0]     radius_out_o,
  output logic [trs_pkg::DO_W-1:0]    density_out_o,
  output logic [trs_pkg::ST_W-1:0]    status_o
);

  typedef enum logic [29:0] {
    ST_IDLE   = 30'd1 << 0,
    ST_LD_RD  = 30'd1 << 1,
    ST_LD_CMP = 30'd1 << 2,
    ST_FN_RA  = 30'd1 << 3,
    ST_FN_RB  = 30'd1 << 4,
    ST_FN_RC  = 30'd1 << 5,
    ST_FN_RD  = 30'd1 << 6,
    ST_FN_M2  = 30'd1 << 7,
    ST_FN_M3  = 30'd1 << 8,
    ST_FN_ACC = 30'd1 << 9,
    ST_SM_M2  = 30'd1 << 10,
    ST_SM_TG  = 30'd1 << 11,
    ST_SM_BS  = 30'd1 << 12,
    ST_SM_BC  = 30'd1 << 13,
    ST_SM_R2  = 30'd1 << 14,
    ST_SM_AVG = 30'd1 << 15,
    ST_SM_O1  = 30'd1 << 16,
    ST_DN_A   = 30'd1 << 17,
    ST_DN_B   = 30'd1 << 18,
    ST_DN_BS  = 30'd1 << 19,
    ST_DN_BC  = 30'd1 << 20,
    ST_DN_L0  = 30'd1 << 21,
    ST_DN_L1  = 30'd1 << 22,
    ST_DN_M2  = 30'd1 << 23,
    ST_DN_DV  = 30'd1 << 24,
    ST_DN_F   = 30'd1 << 25,
    ST_DN_T   = 30'd1 << 26,
    ST_DN_D   = 30'd1 << 27,
    ST_DN_Q   = 30'd1 << 28,
    ST_ARITH  = 30'd1 << 29
  } state_e;

  localparam int unsigned AW = trs_pkg::ADDR_W;
  localparam int unsigned CW = trs_pkg::CNT_W;
  localparam int unsigned RW = trs_pkg::R_W;
  localparam int unsigned DW = trs_pkg::DEN_W;
  localparam int unsigned WW = trs_pkg::CW_W;
  localparam int unsigned NW = trs_pkg::DIV_N_W;
  localparam int unsigned BW = trs_pkg::MUL_B_W;
  localparam int unsigned KW = trs_pkg::ACNT_W;
  localparam int unsigned PW = trs_pkg::PROD_W;

  // memories
  logic [RW-1:0] rad_mem [trs_pkg::MAX_POINTS];
  logic [DW-1:0] den_mem [trs_pkg::MAX_POINTS];
  logic [WW-1:0] cw_mem  [trs_pkg::MAX_POINTS];
  logic [RW-1:0] rd_rad_q;
  logic [DW-1:0] rd_den_q;
  logic [WW-1:0] rd_cw_q;
  logic [AW-1:0] rd_addr;
  logic          tab_we, cw_we;
  logic [AW-1:0] tab_waddr;
  logic [RW-1:0] tab_wrad;
  logic [DW-1:0] tab_wden;
  logic [WW-1:0] cw_wdata;

  // control
  state_e        state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rdy_q, rdy_d;
  logic [WW-1:0] tot_q, tot_d;
  logic [CW-1:0] idx_q, idx_d, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  // item registers
  logic [RW-1:0] rad_q, rad_d, ra_q, ra_d, rb_q, rb_d, rc_q, rc_d;
  logic [DW-1:0] pden_q, pden_d, da_q, da_d, db_q, db_d, f_q, f_d;
  logic [trs_pkg::U_W-1:0] uni_q, uni_d;
  logic [WW-1:0] sum_q, sum_d, tmp_q, tmp_d, tgt_q, tgt_d;

  // shared unit
  logic [WW-1:0] acc_q, acc_d, op_q, op_d;
  logic [NW-1:0] sh_q, sh_d;
  logic [KW-1:0] acnt_q, acnt_d;
  logic          div_q, div_d;
  logic [WW+1:0] alu_x, alu_y, alu_res;
  logic          alu_ge;
  logic [PW-1:0] prod;
  logic          go_mul, go_div;
  logic [WW-1:0] go_a;
  logic [NW-1:0] go_b;
  state_e        go_ret;

  // result
  logic                     done_q, done_d;
  logic [RW-1:0]            ro_q, ro_d;
  logic [trs_pkg::DO_W-1:0] do_q, do_d;
  logic [trs_pkg::ST_W-1:0] st_q, st_d;
  logic                     resp;
  trs_pkg::status_e         resp_st;
  logic [RW-1:0]            resp_r;
  logic [trs_pkg::DO_W-1:0] resp_den;

  // helpers
  logic [CW-1:0] n_m1;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c;
  logic [RW+1:0] r3, left2, right2, dr2;
  logic [WW-1:0] sum_new;
  logic [48:0]   rnd;
  logic [RW:0]   avg;
  logic [WW-1:0] dd;

  assign prod    = {acc_q, sh_q[BW-1:0]};
  assign n_m1    = cnt_q - CW'(1);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c   = mid_sum[CW:1];
  assign r3      = {1'b0, ra_q, 1'b0} + {2'b00, ra_q};
  assign left2   = (idx_q == '0) ? ((r3 > {2'b00, rb_q}) ? r3 - {2'b00, rb_q} : '0)
                                 : {2'b00, ra_q} + {2'b00, rb_q};
  assign right2  = (idx_q == n_m1) ? r3 - {2'b00, rb_q} : {2'b00, ra_q} + {2'b00, rc_q};
  assign dr2     = right2 - left2;
  assign sum_new = sum_q + WW'(prod[65:17]);
  assign rnd     = {1'b0, prod[47:0]} + 49'hFFFFFF;
  assign avg     = {1'b0, rb_q} + {1'b0, rd_rad_q};
  assign dd      = (|prod[PW-1:84]) ? '1 : prod[83:20];

  assign alu_x   = div_q ? {1'b0, acc_q, sh_q[NW-1]} : {2'b00, acc_q};
  assign alu_y   = div_q ? ~{2'b00, op_q} : (sh_q[0] ? {2'b00, op_q} : '0);
  assign alu_res = alu_x + alu_y + (WW+2)'(div_q);
  assign alu_ge  = ~alu_res[WW+1];

  always_comb begin
    state_d = state_q;  ret_d = ret_q;   cnt_d = cnt_q;   rdy_d = rdy_q;
    tot_d = tot_q;      idx_d = idx_q;   lo_d = lo_q;     hi_d = hi_q;
    mid_d = mid_q;      rad_d = rad_q;   ra_d = ra_q;     rb_d = rb_q;
    rc_d = rc_q;        pden_d = pden_q; da_d = da_q;     db_d = db_q;
    f_d = f_q;          uni_d = uni_q;   sum_d = sum_q;   tmp_d = tmp_q;
    tgt_d = tgt_q;      acc_d = acc_q;   op_d = op_q;     sh_d = sh_q;
    acnt_d = acnt_q;    div_d = div_q;
    ro_d = ro_q;        do_d = do_q;     st_d = st_q;     done_d = 1'b0;
    rd_addr = '0;       tab_we = 1'b0;   cw_we = 1'b0;
    tab_waddr = idx_q[AW-1:0];
    tab_wrad = rad_q;   tab_wden = pden_q;
    cw_wdata = sum_new;
    go_mul = 1'b0;      go_div = 1'b0;   go_a = '0;       go_b = '0;
    go_ret = ST_IDLE;
    resp = 1'b0;        resp_st = trs_pkg::STS_OK;
    resp_r = '0;        resp_den = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          rad_d  = radius_i;
          pden_d = point_density_i;
          uni_d  = uniform_i;
          case (cmd_i)
            trs_pkg::CMD_LOAD: begin
              if (cnt_q == CW'(trs_pkg::MAX_POINTS)) begin
                resp = 1'b1; resp_st = trs_pkg::STS_FULL;
              end else begin
                idx_d = cnt_q; state_d = ST_LD_RD;
              end
            end
            trs_pkg::CMD_FINISH: begin
              rdy_d = 1'b0;
              if (cnt_q < CW'(2)) begin
                resp = 1'b1; resp_st = trs_pkg::STS_TOO_FEW;
              end else begin
                idx_d = '0; sum_d = '0; state_d = ST_FN_RA;
              end
            end
            trs_pkg::CMD_SAMPLE: begin
              if (!rdy_q) begin
                resp = 1'b1; resp_st = trs_pkg::STS_NOT_BUILT;
              end else begin
                go_mul = 1'b1; go_a = WW'(tot_q[WW-1:24]);
                go_b = NW'(uniform_i); go_ret = ST_SM_M2;
              end
            end
            default: begin
              if (!rdy_q) begin
                resp = 1'b1; resp_st = trs_pkg::STS_NOT_BUILT;
              end else begin
                rd_addr = '0; state_d = ST_DN_A;
              end
            end
          endcase
        end
      end
      ST_LD_RD: begin
        if (idx_q == '0) begin
          tab_we = 1'b1; cnt_d = cnt_q + CW'(1); rdy_d = 1'b0; resp = 1'b1;
        end else begin
          rd_addr = AW'(idx_q - CW'(1)); state_d = ST_LD_CMP;
        end
      end
      ST_LD_CMP: begin
        tab_we = 1'b1;
        if (rd_rad_q > rad_q) begin
          tab_wrad = rd_rad_q; tab_wden = rd_den_q;
          idx_d = idx_q - CW'(1); state_d = ST_LD_RD;
        end else begin
          cnt_d = cnt_q + CW'(1); rdy_d = 1'b0; resp = 1'b1;
        end
      end
      ST_FN_RA: begin
        rd_addr = idx_q[AW-1:0]; state_d = ST_FN_RB;
      end
      ST_FN_RB: begin
        ra_d = rd_rad_q; da_d = rd_den_q;
        rd_addr = (idx_q == '0) ? AW'(1) : AW'(idx_q - CW'(1));
        state_d = ST_FN_RC;
      end
      ST_FN_RC: begin
        rb_d = rd_rad_q;
        rd_addr = (idx_q == n_m1) ? AW'(idx_q - CW'(1)) : AW'(idx_q + CW'(1));
        state_d = ST_FN_RD;
      end
      ST_FN_RD: begin
        rc_d = rd_rad_q;
        go_mul = 1'b1; go_a = WW'(ra_q); go_b = NW'(ra_q); go_ret = ST_FN_M2;
      end
      ST_FN_M2: begin
        go_mul = 1'b1; go_a = WW'(prod[47:16]); go_b = NW'(da_q); go_ret = ST_FN_M3;
      end
      ST_FN_M3: begin
        go_mul = 1'b1; go_a = WW'(prod[55:16]); go_b = NW'(dr2); go_ret = ST_FN_ACC;
      end
      ST_FN_ACC: begin
        cw_we = 1'b1; sum_d = sum_new;
        if (idx_q == n_m1) begin
          tot_d = sum_new; resp = 1'b1;
          if (sum_new == '0) resp_st = trs_pkg::STS_ZERO_WEIGHT;
          else rdy_d = 1'b1;
        end else begin
          idx_d = idx_q + CW'(1); state_d = ST_FN_RA;
        end
      end
      ST_SM_M2: begin
        tmp_d = prod[WW-1:0];
        go_mul = 1'b1; go_a = WW'(tot_q[23:0]); go_b = NW'(uni_q); go_ret = ST_SM_TG;
      end
      ST_SM_TG: begin
        tgt_d = tmp_q + WW'(rnd[48:24]);
        lo_d = '0; hi_d = cnt_q; state_d = ST_SM_BS;
      end
      ST_SM_BS: begin
        if (lo_q < hi_q) begin
          mid_d = mid_c; rd_addr = mid_c[AW-1:0]; state_d = ST_SM_BC;
        end else if (lo_q == cnt_q) begin
          rd_addr = n_m1[AW-1:0]; state_d = ST_SM_O1;
        end else if (lo_q == '0) begin
          rd_addr = '0; state_d = ST_SM_O1;
        end else begin
          rd_addr = AW'(lo_q - CW'(1)); state_d = ST_SM_R2;
        end
      end
      ST_SM_BC: begin
        if (rd_cw_q >= tgt_q) hi_d = mid_q;
        else lo_d = mid_q + CW'(1);
        state_d = ST_SM_BS;
      end
      ST_SM_R2: begin
        rb_d = rd_rad_q; rd_addr = lo_q[AW-1:0]; state_d = ST_SM_AVG;
      end
      ST_SM_AVG: begin
        resp = 1'b1; resp_r = avg[RW:1];
      end
      ST_SM_O1: begin
        resp = 1'b1; resp_r = rd_rad_q;
      end
      ST_DN_A: begin
        ra_d = rd_rad_q; da_d = rd_den_q;
        if (rad_q <= rd_rad_q) begin
          f_d = rd_den_q; state_d = ST_DN_T;
        end else begin
          rd_addr = n_m1[AW-1:0]; state_d = ST_DN_B;
        end
      end
      ST_DN_B: begin
        if (rad_q >= rd_rad_q) begin
          resp = 1'b1;
        end else begin
          lo_d = CW'(1); hi_d = n_m1; state_d = ST_DN_BS;
        end
      end
      ST_DN_BS: begin
        if (lo_q < hi_q) begin
          mid_d = mid_c; rd_addr = mid_c[AW-1:0]; state_d = ST_DN_BC;
        end else begin
          rd_addr = AW'(lo_q - CW'(1)); state_d = ST_DN_L0;
        end
      end
      ST_DN_BC: begin
        if (rd_rad_q >= rad_q) hi_d = mid_q;
        else lo_d = mid_q + CW'(1);
        state_d = ST_DN_BS;
      end
      ST_DN_L0: begin
        ra_d = rd_rad_q; da_d = rd_den_q; rd_addr = lo_q[AW-1:0]; state_d = ST_DN_L1;
      end
      ST_DN_L1: begin
        rb_d = rd_rad_q; db_d = rd_den_q;
        go_mul = 1'b1; go_a = WW'(da_q); go_b = NW'(rd_rad_q - rad_q);
        go_ret = ST_DN_M2;
      end
      ST_DN_M2: begin
        tmp_d = prod[WW-1:0];
        go_mul = 1'b1; go_a = WW'(db_q); go_b = NW'(rad_q - ra_q); go_ret = ST_DN_DV;
      end
      ST_DN_DV: begin
        go_div = 1'b1; go_a = WW'(rb_q - ra_q);
        go_b = {1'b0, tmp_q[47:0]} + {1'b0, prod[47:0]};
        go_ret = ST_DN_F;
      end
      ST_DN_F: begin
        f_d = sh_q[DW-1:0]; state_d = ST_DN_T;
      end
      ST_DN_T: begin
        go_mul = 1'b1; go_a = tot_q; go_b = NW'(trs_pkg::FOURPI_Q20); go_ret = ST_DN_D;
      end
      ST_DN_D: begin
        if (dd == '0) begin
          resp = 1'b1; resp_den = '1;
        end else begin
          go_div = 1'b1; go_a = dd; go_b = {1'b0, f_q, 24'd0}; go_ret = ST_DN_Q;
        end
      end
      ST_DN_Q: begin
        resp = 1'b1;
        resp_den = (|sh_q[NW-1:32]) ? '1 : sh_q[31:0];
      end
      ST_ARITH: begin
        acnt_d = acnt_q + KW'(1);
        if (div_q) begin
          acc_d = alu_ge ? alu_res[WW-1:0] : alu_x[WW-1:0];
          sh_d  = {sh_q[NW-2:0], alu_ge};
        end else begin
          acc_d = alu_res[WW:1];
          sh_d  = {{(NW-BW){1'b0}}, alu_res[0], sh_q[BW-1:1]};
        end
        if (acnt_q == (div_q ? KW'(NW - 1) : KW'(BW - 1))) state_d = ret_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (go_mul || go_div) begin
      acc_d = '0; op_d = go_a; sh_d = go_b; div_d = go_div;
      acnt_d = '0; ret_d = go_ret; state_d = ST_ARITH;
    end
    if (resp) begin
      done_d = 1'b1; st_d = resp_st; ro_d = resp_r; do_d = resp_den;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      cnt_q   <= '0;
      rdy_q   <= 1'b0;
      tot_q   <= '0;
      done_q  <= 1'b0;
      acnt_q  <= '0;
      div_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      rdy_q   <= rdy_d;
      tot_q   <= tot_d;
      done_q  <= done_d;
      acnt_q  <= acnt_d;
      div_q   <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;   lo_q <= lo_d;     hi_q <= hi_d;   mid_q <= mid_d;
    rad_q <= rad_d;   ra_q <= ra_d;     rb_q <= rb_d;   rc_q <= rc_d;
    pden_q <= pden_d; da_q <= da_d;     db_q <= db_d;   f_q <= f_d;
    uni_q <= uni_d;   sum_q <= sum_d;   tmp_q <= tmp_d; tgt_q <= tgt_d;
    acc_q <= acc_d;   op_q <= op_d;     sh_q <= sh_d;
    ro_q <= ro_d;     do_q <= do_d;     st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      rad_mem[tab_waddr] <= tab_wrad;
      den_mem[tab_waddr] <= tab_wden;
    end
    if (cw_we) begin
      cw_mem[idx_q[AW-1:0]] <= cw_wdata;
    end
    rd_rad_q <= rad_mem[rd_addr];
    rd_den_q <= den_mem[rd_addr];
    rd_cw_q  <= cw_mem[rd_addr];
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign radius_out_o  = ro_q;
  assign density_out_o = do_q;
  assign status_o      = st_q;

  `TRS_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_q, state_q == ST_IDLE)
  `TRS_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CW'(trs_pkg::MAX_POINTS))
  `TRS_ASSERT_IMPL(a_rdy_cnt, clk_i, rst_ni, rdy_q, cnt_q >= CW'(2))
  `TRS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy && !done_d, busy)

endmodule
